### rtl/serial_counter_frame_parser_assert.svh
// assertion macros used by the checker file of the serial counter frame parser
// depends on: nothing; the including scope provides clk and arst_n
`ifndef SERIAL_COUNTER_FRAME_PARSER_ASSERT_SVH
`define SERIAL_COUNTER_FRAME_PARSER_ASSERT_SVH

// clocked check, off while reset is asserted
`define SCFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define SCFP_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/scfp_pkg.sv
// shared constants, command/status types and slot decoders of the frame parser
// depends on: nothing
package scfp_pkg;

	localparam int CHANNELS     = 8;
	localparam int IDX_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [7:0] START_BYTE = 8'hFE;
	localparam logic [7:0] END_BYTE   = 8'hFF;
	localparam logic [7:0] MIN_LEN    = 8'd3;
	localparam logic [7:0] TYPE_SYNC  = 8'd1;
	localparam logic [7:0] POS_TYPE   = 8'd2;
	localparam logic [7:0] POS_SYNC   = 8'd4;

	localparam int COUNT_BASE   = 4;
	localparam int COUNT_STRIDE = 6;
	localparam int IO_BASE      = 52;
	localparam int IO_STRIDE    = 3;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic load_len;
		logic body_write;
		logic load_check;
		logic emit_start;
		logic emit_next;
	} scfp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_hit;
		logic len_short;
		logic body_done;
		logic frame_ok;
		logic emit_last;
	} scfp_sts_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] ch;
		logic [1:0]       byte_sel;
	} cnt_slot_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] ch;
	} io_slot_t;

	// which count word and which byte of it a frame position lands on
	function automatic cnt_slot_t count_slot(input logic [7:0] pos);
		cnt_slot_t  s;
		logic [7:0] base;
		s = '0;
		for (int k = 0; k < CHANNELS; k++) begin
			base = 8'(COUNT_BASE + COUNT_STRIDE * k);
			if (pos >= base && pos < base + 8'd4) begin
				s.hit      = 1'b1;
				s.ch       = IDX_W'(k);
				s.byte_sel = 2'(pos - base);
			end
		end
		return s;
	endfunction

	// which io byte a frame position lands on
	function automatic io_slot_t io_slot(input logic [7:0] pos);
		io_slot_t s;
		s = '0;
		for (int k = 0; k < CHANNELS; k++) begin
			if (pos == 8'(IO_BASE + IO_STRIDE * k)) begin
				s.hit = 1'b1;
				s.ch  = IDX_W'(k);
			end
		end
		return s;
	endfunction

endpackage

### rtl/scfp_datapath.sv
// datapath of the frame parser: frame registers, staged counts, previous counts,
// checksum and the result register
// depends on: scfp_pkg
module scfp_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        rx_byte,
	input  scfp_pkg::scfp_cmd_t cmd,
	output scfp_pkg::scfp_sts_t sts,
	output logic              kind,
	output logic [7:0]        sync_mode,
	output logic [2:0]        channel,
	output logic [31:0]       count_value,
	output logic [7:0]        io_value,
	output logic              channel_changed,
	output logic              any_changed,
	output logic              last
);
	import scfp_pkg::*;

	logic [7:0]       len_q, pos_q, sum_q, chk_q, type_q, sync_q;
	logic [31:0]      cnt_q  [CHANNELS];
	logic [7:0]       io_q   [CHANNELS];
	logic [31:0]      prev_q [CHANNELS];
	logic [IDX_W-1:0] idx_q;

	logic             kind_q, changed_q, any_q, last_q;
	logic [7:0]       smode_q, ioval_q;
	logic [2:0]       chan_q;
	logic [31:0]      count_q;

	logic [7:0]       pos_next;
	cnt_slot_t        cslot;
	io_slot_t         islot;
	logic             any_diff;
	logic             is_sync;
	logic [IDX_W-1:0] li;

	// next body position and where it lands
	assign pos_next = pos_q + 8'd1;
	assign cslot    = count_slot(pos_next);
	assign islot    = io_slot(pos_next);
	assign is_sync  = (type_q == TYPE_SYNC);
	assign li       = cmd.emit_start ? '0 : idx_q + IDX_W'(1);

	// any staged count differing from its stored predecessor
	always_comb begin
		any_diff = 1'b0;
		for (int k = 0; k < CHANNELS; k++) begin
			if (cnt_q[k] != prev_q[k]) any_diff = 1'b1;
		end
	end

	// status to the controller
	always_comb begin
		sts.start_hit = (rx_byte == START_BYTE);
		sts.len_short = (rx_byte < MIN_LEN);
		sts.body_done = (pos_next >= len_q);
		sts.frame_ok  = (rx_byte == END_BYTE) && (chk_q == sum_q);
		sts.emit_last = last_q;
	end

	// frame registers and staging
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			pos_q  <= '0;
			sum_q  <= '0;
			chk_q  <= '0;
			type_q <= '0;
			sync_q <= '0;
			for (int k = 0; k < CHANNELS; k++) begin
				cnt_q[k] <= '0;
				io_q[k]  <= '0;
			end
		end else if (cmd.clear) begin
			len_q  <= '0;
			pos_q  <= '0;
			sum_q  <= '0;
			chk_q  <= '0;
			type_q <= '0;
			sync_q <= '0;
			for (int k = 0; k < CHANNELS; k++) begin
				cnt_q[k] <= '0;
				io_q[k]  <= '0;
			end
		end else if (cmd.load_len) begin
			len_q <= rx_byte;
			pos_q <= 8'd1;
			sum_q <= rx_byte;
		end else if (cmd.body_write) begin
			pos_q <= pos_next;
			sum_q <= sum_q + rx_byte;
			if (pos_next == POS_TYPE) type_q <= rx_byte;
			if (pos_next == POS_SYNC) sync_q <= rx_byte;
			if (cslot.hit) begin
				case (cslot.byte_sel)
					2'd0:    cnt_q[cslot.ch][31:24] <= rx_byte;
					2'd1:    cnt_q[cslot.ch][23:16] <= rx_byte;
					2'd2:    cnt_q[cslot.ch][15:8]  <= rx_byte;
					default: cnt_q[cslot.ch][7:0]   <= rx_byte;
				endcase
			end
			if (islot.hit) io_q[islot.ch] <= rx_byte;
		end else if (cmd.load_check) begin
			chk_q <= rx_byte;
		end
	end

	// previous counts and emit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			for (int k = 0; k < CHANNELS; k++) prev_q[k] <= '0;
		end else if (cmd.emit_start || cmd.emit_next) begin
			idx_q <= li;
			if (!is_sync) prev_q[li] <= cnt_q[li];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit_start || cmd.emit_next) begin
			if (is_sync) begin
				kind_q    <= 1'b0;
				smode_q   <= sync_q;
				chan_q    <= '0;
				count_q   <= '0;
				ioval_q   <= '0;
				changed_q <= 1'b0;
				any_q     <= 1'b0;
				last_q    <= 1'b1;
			end else begin
				kind_q    <= 1'b1;
				smode_q   <= '0;
				chan_q    <= 3'(li);
				count_q   <= cnt_q[li];
				ioval_q   <= io_q[li];
				changed_q <= (cnt_q[li] != prev_q[li]);
				if (cmd.emit_start) any_q <= any_diff;
				last_q    <= (li == IDX_W'(CHANNELS - 1));
			end
		end
	end

	assign kind            = kind_q;
	assign sync_mode       = smode_q;
	assign channel         = chan_q;
	assign count_value     = count_q;
	assign io_value        = ioval_q;
	assign channel_changed = changed_q;
	assign any_changed     = any_q;
	assign last            = last_q;

endmodule

### rtl/scfp_ctrl.sv
// controller of the frame parser: frame phase state machine and handshakes
// depends on: scfp_pkg
module scfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  scfp_pkg::scfp_sts_t sts,
	output scfp_pkg::scfp_cmd_t cmd
);
	import scfp_pkg::*;

	localparam logic [2:0] ST_HUNT  = 3'd0;
	localparam logic [2:0] ST_LEN   = 3'd1;
	localparam logic [2:0] ST_BODY  = 3'd2;
	localparam logic [2:0] ST_CHECK = 3'd3;
	localparam logic [2:0] ST_END   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic       in_fire, out_fire;

	assign in_ready  = (state_q != ST_EMIT);
	assign out_valid = (state_q == ST_EMIT);
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_LEN: begin
				if (in_fire) begin
					if (sts.len_short) begin
						state_d = ST_HUNT;
					end else begin
						cmd.load_len = 1'b1;
						state_d      = ST_BODY;
					end
				end
			end
			ST_BODY: begin
				if (in_fire) begin
					cmd.body_write = 1'b1;
					if (sts.body_done) state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (in_fire) begin
					cmd.load_check = 1'b1;
					state_d        = ST_END;
				end
			end
			ST_END: begin
				if (in_fire) begin
					if (sts.frame_ok) begin
						cmd.emit_start = 1'b1;
						state_d        = ST_EMIT;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_EMIT: begin
				if (out_fire) begin
					if (sts.emit_last) state_d = ST_HUNT;
					else cmd.emit_next = 1'b1;
				end
			end
			default: begin
				if (in_fire) begin
					state_d = ST_HUNT;
					if (sts.start_hit) begin
						cmd.clear = 1'b1;
						state_d   = ST_LEN;
					end
				end
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/serial_counter_frame_parser.sv
// Serial counter frame parser, top level.
// depends on: scfp_pkg, scfp_ctrl, scfp_datapath
//
// Input channel (in_valid/in_ready/rx_byte) takes one received serial byte a
// beat. The parser hunts for 0xFE, takes the length byte, the frame bytes, the
// checksum and the 0xFF end byte; a bad or short frame is dropped silently.
// Output channel (out_valid/out_ready) gives one result a beat: one sync
// request for a frame of type 1, else one counter report per channel, the
// final one marked by last.
// Latency: the first result of a frame is shown in the cycle after the end
// byte is taken. The burst then runs one result a cycle while out_ready is
// high. Throughput: one byte a cycle while parsing. While a burst is pending
// in_ready is low, so no byte is taken until the burst has ended; the result
// register and the phase state machine set these figures. A stalled receiver
// holds the result register and the burst, and input waits. Reset puts the
// parser in the hunt phase, drops any burst and clears the stored previous
// counts to zero.
module serial_counter_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  sync_mode,
	output logic [2:0]  channel,
	output logic [31:0] count_value,
	output logic [7:0]  io_value,
	output logic        channel_changed,
	output logic        any_changed,
	output logic        last
);
	import scfp_pkg::*;

	scfp_cmd_t cmd;
	scfp_sts_t sts;

	// phase control and handshakes
	scfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// frame storage and result register
	scfp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.rx_byte         (rx_byte),
		.cmd             (cmd),
		.sts             (sts),
		.kind            (kind),
		.sync_mode       (sync_mode),
		.channel         (channel),
		.count_value     (count_value),
		.io_value        (io_value),
		.channel_changed (channel_changed),
		.any_changed     (any_changed),
		.last            (last)
	);

endmodule

### rtl/scfp_checker.sv
// port-level checks of the frame parser and the bind that attaches them
// depends on: scfp_pkg, serial_counter_frame_parser_assert.svh
`include "serial_counter_frame_parser_assert.svh"

module scfp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [7:0]  sync_mode,
	input logic [2:0]  channel,
	input logic [31:0] count_value,
	input logic [7:0]  io_value,
	input logic        channel_changed,
	input logic        any_changed,
	input logic        last
);
	import scfp_pkg::*;

	localparam logic [2:0] TOP_CH = 3'(CHANNELS - 1);

	logic [54:0] result_bits;

	// whole result beat as one vector
	assign result_bits = {kind, sync_mode, channel, count_value, io_value,
		channel_changed, any_changed, last};

	// no result pending out of reset
	`SCFP_ASSERT_RST(a_reset_idle, !arst_n |-> !out_valid, "result valid during reset")

	// input is held off while a burst is pending
	`SCFP_ASSERT(a_no_input_in_burst, out_valid |-> !in_ready, "byte taken during burst")

	// a burst runs on until its last beat
	`SCFP_ASSERT(a_burst_runs, out_valid && out_ready && !last |=> out_valid, "burst broken")

	// a stalled result beat holds its payload
	`SCFP_ASSERT(a_hold_stalled, out_valid && !out_ready |=> out_valid && $stable(result_bits), "beat changed while stalled")

	// sync is a single beat, reports end on the top channel
	`SCFP_ASSERT(a_last_place, out_valid |-> (last == (!kind || channel == TOP_CH)), "last misplaced")

endmodule

bind serial_counter_frame_parser scfp_checker u_scfp_checker (.*);
